// ----- rtl/sgm_pkg.sv -----
package sgm_pkg;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int MAG_W  = 11;
    localparam int POS_W  = 8;
    localparam int CFG_W  = 9;

    // Sum of squares of two gradients fits in twice the root width
    localparam int SQ_W   = 2 * MAG_W;

    // Default line length and the fixed frame height limit
    localparam int DEF_MAX_WIDTH = 256;
    localparam int MAX_HEIGHT    = 256;

    // Smallest legal image dimension
    localparam int MIN_DIM = 3;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Result word: grad_x in the lowest bits, zero pad on top
    localparam int OUT_BITS   = 2 * GRAD_W + MAG_W + 2 * POS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_BITS;

    typedef struct packed {
        logic [OUT_PAD_W-1:0]    pad;
        logic [POS_W-1:0]        centre_col;
        logic [POS_W-1:0]        centre_row;
        logic [MAG_W-1:0]        magnitude;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_x;
    } out_word_t;

endpackage

// ----- rtl/sobel_gradient_magnitude_unit.sv -----
// 3x3 Sobel edge detector over a raster stream of 8-bit grey pixels. Each
// accepted pixel reads the two previous rows at its column from one line
// store RAM (16 bits per column: row r-2 above row r-1), shifts the 3x3
// window, and writes the column back. Once the window lies fully inside the
// frame (row >= 2 and column >= 2) one result word is given for the window
// centre: grad_x, grad_y (top minus bottom), the integer square root of
// grad_x^2 + grad_y^2, the centre position, and tlast on the last result of
// the frame. Border pixels produce no word. A pixel that yields no word
// goes through accept, then RAM read-modify-write; one that yields a
// word goes through accept, window update, squaring, sum of squares,
// then the bit-serial square root unit which resolves one root bit per
// cycle, and the load of the output register once that is free. A
// finished word waits in the output register while the next pixel is taken.
// The line store has no clearing pass: it must be filled by the rows of a
// frame before use.
// image_width is clamped to 3..MAX_WIDTH and image_height to 3..256.
module sobel_gradient_magnitude_unit #(
    parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration writes
    input  logic                             cfg_wr_en,
    input  logic [sgm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sgm_pkg::CFG_W-1:0]        cfg_wdata,

    // Pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sgm_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    input  logic                             s_tuser,   // frame_start

    // Result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [10:0] grad_x, [21:11] grad_y, [32:22] magnitude,
    // [40:33] centre_row, [48:41] centre_col, [55:49] zero
    output logic [sgm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast    // frame_last
);
    import sgm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int SUM_W = PIX_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SQ,
        S_ADD,
        S_ROOT
    } state_t;

    state_t           state_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CW-1:0]    col_reg;
    logic [POS_W-1:0] row_reg;
    logic             m_tvalid_reg;

    // Current item
    logic [PIX_W-1:0] px_reg;
    logic [CW-1:0]    c_reg;
    logic [POS_W-1:0] r_reg;

    // Window: previous two columns, rows top, mid, bottom
    logic [PIX_W-1:0] win0_reg [3];
    logic [PIX_W-1:0] win1_reg [3];

    // Result in flight
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic [POS_W-1:0]         crow_reg;
    logic [POS_W-1:0]         ccol_reg;
    logic                     last_reg;
    out_word_t                out_reg;
    logic                     out_last_reg;

    logic                     accept;
    logic [CW-1:0]            c_in;
    logic [2*PIX_W-1:0]       ram_rdata;
    logic [PIX_W-1:0]         top_px;
    logic [PIX_W-1:0]         mid_px;
    logic [LW-1:0]            w_eff;
    logic [CFG_W-1:0]         h_eff;
    logic [LW-1:0]            c_inc;
    logic [CFG_W-1:0]         r_inc;
    logic                     row_end;
    logic                     frame_end;
    logic                     emit;
    logic [SUM_W-1:0]         right_sum, left_sum, top_sum, bot_sum;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [LW-1:0]            c_m1;
    logic [SQ_W-1:0]          sq_sum;
    logic                     root_start;
    logic                     root_busy;
    logic [MAG_W-1:0]         root;
    logic                     out_free;
    logic                     out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Frame start restarts the position at the accept edge
    assign c_in = s_tuser ? '0 : col_reg;

    // Clamped image dimensions
    always_comb begin
        if (LW'(width_reg) < LW'(MIN_DIM)) begin
            w_eff = LW'(MIN_DIM);
        end else if (LW'(width_reg) > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = LW'(width_reg);
        end
        if (height_reg < CFG_W'(MIN_DIM)) begin
            h_eff = CFG_W'(MIN_DIM);
        end else if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // Position bookkeeping for the item in S_UPD
    assign c_inc     = LW'(c_reg) + 1'b1;
    assign r_inc     = CFG_W'(r_reg) + 1'b1;
    assign row_end   = (c_inc >= w_eff);
    assign frame_end = (r_inc >= h_eff);
    assign emit      = (r_reg >= POS_W'(2)) && (c_reg >= CW'(2));
    assign c_m1      = LW'(c_reg) - 1'b1;

    // Line store: one 16-bit word per column, {row r-2, row r-1}
    assign top_px = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_px = ram_rdata[PIX_W-1:0];

    sgm_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == S_UPD),
        .wr_addr (c_reg),
        .wr_data ({mid_px, px_reg}),
        .rd_en   (accept),
        .rd_addr (c_in),
        .rd_data (ram_rdata)
    );

    // Sobel sums on the shifted window; new column is top_px, mid_px, px_reg
    assign right_sum = SUM_W'(top_px) + {1'b0, mid_px, 1'b0} + SUM_W'(px_reg);
    assign left_sum  = SUM_W'(win0_reg[0]) + {1'b0, win0_reg[1], 1'b0}
                     + SUM_W'(win0_reg[2]);
    assign top_sum   = SUM_W'(win0_reg[0]) + {1'b0, win1_reg[0], 1'b0}
                     + SUM_W'(top_px);
    assign bot_sum   = SUM_W'(win0_reg[2]) + {1'b0, win1_reg[2], 1'b0}
                     + SUM_W'(px_reg);
    assign gx = $signed(GRAD_W'(right_sum)) - $signed(GRAD_W'(left_sum));
    assign gy = $signed(GRAD_W'(top_sum)) - $signed(GRAD_W'(bot_sum));

    // Root of the sum of squares; squares settle in S_SQ, start in S_ADD
    assign sq_sum     = sqx_reg + sqy_reg;
    assign root_start = (state_reg == S_ADD);

    sgm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (sq_sum),
        .busy    (root_busy),
        .root    (root)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_ROOT) && !root_busy && out_free;

    // Control: state, configuration, position, window, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            width_reg    <= CFG_W'(DEF_MAX_WIDTH);
            height_reg   <= CFG_W'(MAX_HEIGHT);
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                win0_reg[k] <= '0;
                win1_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // A new word replaces the one leaving in the same cycle
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    win0_reg[0] <= win1_reg[0];
                    win0_reg[1] <= win1_reg[1];
                    win0_reg[2] <= win1_reg[2];
                    win1_reg[0] <= top_px;
                    win1_reg[1] <= mid_px;
                    win1_reg[2] <= px_reg;
                    if (row_end) begin
                        col_reg <= '0;
                        row_reg <= frame_end ? '0 : r_inc[POS_W-1:0];
                    end else begin
                        col_reg <= c_inc[CW-1:0];
                        row_reg <= r_reg;
                    end
                    state_reg <= emit ? S_SQ : S_IDLE;
                end
                S_SQ: begin
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg <= s_tdata;
            c_reg  <= c_in;
            r_reg  <= s_tuser ? '0 : row_reg;
        end
        if (state_reg == S_UPD) begin
            gx_reg   <= gx;
            gy_reg   <= gy;
            crow_reg <= r_reg - 1'b1;
            ccol_reg <= c_m1[POS_W-1:0];
            last_reg <= row_end && frame_end;
        end
        sqx_reg <= SQ_W'(gx_reg) * SQ_W'(gx_reg);
        sqy_reg <= SQ_W'(gy_reg) * SQ_W'(gy_reg);
        if (out_load) begin
            out_reg.pad        <= '0;
            out_reg.centre_col <= ccol_reg;
            out_reg.centre_row <= crow_reg;
            out_reg.magnitude  <= root;
            out_reg.grad_y     <= gy_reg;
            out_reg.grad_x     <= gx_reg;
            out_last_reg       <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    // Line store is written exactly once per accepted pixel, right after its read
    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> $past(accept))
        else $error("line store write without a preceding read");

    // A word is only loaded from a finished root
    a_load_after_root: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_ROOT && !root_busy))
        else $error("result word loaded before the root was done");

    // The root is the floor of the square root of the sum of squares
    a_root_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT && !root_busy) |->
            ({11'd0, root} * {11'd0, root} <= sq_sum) &&
            (({11'd0, root} + 22'd1) * ({11'd0, root} + 22'd1) > sq_sum))
        else $error("square root result is wrong");

    // No pixel is taken while the root unit is busy
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        root_busy |-> !s_tready)
        else $error("pixel accepted while the root unit is busy");

endmodule

// ----- rtl/sgm_ram.sv -----
module sgm_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Single write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sgm_isqrt.sv -----
module sgm_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sgm_pkg::SQ_W-1:0]  operand,
    output logic                      busy,
    output logic [sgm_pkg::MAG_W-1:0] root
);
    import sgm_pkg::*;

    localparam int REM_W  = MAG_W + 2;
    localparam int STEP_W = $clog2(MAG_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SQ_W-1:0]   op_reg, op_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  root_reg, root_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // One result bit per cycle: bring in the next two operand bits and try
    // 4*root + 1 against the running remainder
    assign rem_sh = {rem_reg[MAG_W-1:0], op_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(MAG_W);
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            op_next = {op_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[MAG_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

    // A started root always runs its full count of steps
    a_start_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && step_reg == STEP_W'(MAG_W))
        else $error("root unit did not start");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg != '0 && step_reg <= STEP_W'(MAG_W))
        else $error("root step count out of range");

    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && step_reg == STEP_W'(1)) |=> !busy_reg)
        else $error("root unit overran its step count");

endmodule

// ----- tb/sv/sobel_gradient_magnitude_unit_tb.sv -----
`timescale 1ns / 100ps

module sobel_gradient_magnitude_unit_tb;

    import sgm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned END_CYCLES     = 40;
    localparam int unsigned HOLD_AT        = 40;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned RANDOM_ITEMS   = 360;

    // One pending input word
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_item_t;

    // One expected gradient result
    typedef struct {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [MAG_W-1:0]         magnitude;
        logic [POS_W-1:0]         centre_row;
        logic [POS_W-1:0]         centre_col;
        logic                     frame_last;
    } sobel_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata = '0;   // [7:0] pixel
    logic                   s_tuser = 1'b0; // frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [10:0] grad_x, [21:11] grad_y, [32:22] magnitude,
    // [40:33] centre_row, [48:41] centre_col, [55:49] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;        // frame_last

    pixel_item_t   pixel_q[$];
    sobel_result_t gradient_q[$];
    pixel_item_t   next_item;
    out_word_t     got;
    sobel_result_t want;

    // Predictor state
    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] height_cfg;
    bit [PIX_W-1:0]   line_mem [2*DEF_MAX_WIDTH];
    int               win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;

    bit          no_idle = 1'b0;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned words_out;
    int unsigned idle_cycles;
    int unsigned mismatches = 0;

    sobel_gradient_magnitude_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input int unsigned val, input int unsigned hi);
        if (val < MIN_DIM) return MIN_DIM;
        if (val > hi) return hi;
        return val;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bias toward black and white so large gradients show up
    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 2) return '0;
        if (k < 4) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Window shift, line store update and gradient for one pixel
    task automatic sobel_step(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned w, h, r, c;
        int gx, gy, sq, root, b, k;
        int top, mid;
        sobel_result_t res;
        w = clamp_dim(width_cfg, DEF_MAX_WIDTH);
        h = clamp_dim(height_cfg, MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        if (c >= DEF_MAX_WIDTH) c = DEF_MAX_WIDTH - 1;
        top = line_mem[DEF_MAX_WIDTH + c];
        mid = line_mem[c];
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        line_mem[DEF_MAX_WIDTH + c] = PIX_W'(mid);
        line_mem[c] = px;

        if (r >= 2 && c >= 2) begin
            gx = (win[0][2] + 2 * win[1][2] + win[2][2])
               - (win[0][0] + 2 * win[1][0] + win[2][0]);
            gy = (win[0][0] + 2 * win[0][1] + win[0][2])
               - (win[2][0] + 2 * win[2][1] + win[2][2]);
            sq = gx * gx + gy * gy;
            // floor square root, one bit at a time from the top
            root = 0;
            for (b = MAG_W - 1; b >= 0; b--) begin
                if ((root + (1 << b)) * (root + (1 << b)) <= sq) root += (1 << b);
            end
            res.grad_x     = gx[GRAD_W-1:0];
            res.grad_y     = gy[GRAD_W-1:0];
            res.magnitude  = root[MAG_W-1:0];
            res.centre_row = POS_W'(r - 1);
            res.centre_col = POS_W'(c - 1);
            res.frame_last = (r + 1 >= h) && (c + 1 >= w);
            gradient_q.push_back(res);
        end

        // end of row / end of frame wrap
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Input side: feeds pixel_q onto the bus and runs the predictor on each accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
            width_cfg = CFG_W'(DEF_MAX_WIDTH);
            height_cfg = CFG_W'(MAX_HEIGHT);
            col_pos = 0;
            row_pos = 0;
            foreach (win[i, j]) win[i][j] = 0;
            foreach (line_mem[i]) line_mem[i] = '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_IMAGE_WIDTH) width_cfg = cfg_wdata;
                else height_cfg = cfg_wdata;
            end
            if (s_tvalid && s_tready) sobel_step(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pixel_q.size() != 0) begin
                    next_item = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.pixel;
                    s_tuser  <= next_item.frame_start;
                    send_gap <= no_idle ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && words_out >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output side: random stalls and compare against the oldest expected result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            words_out  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = out_word_t'(m_tdata);
                words_out <= words_out + 1;
                if (gradient_q.size() == 0) begin
                    if (mismatches < 10) $display("unexpected word %h last %b", m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = gradient_q.pop_front();
                    if (got.grad_x !== want.grad_x || got.grad_y !== want.grad_y ||
                        got.magnitude !== want.magnitude ||
                        got.centre_row !== want.centre_row ||
                        got.centre_col !== want.centre_col ||
                        m_tlast !== want.frame_last || got.pad !== '0) begin
                        if (mismatches < 10) begin
                            $display("mismatch (exp/got): gx %0d/%0d gy %0d/%0d mag %0d/%0d",
                                     want.grad_x, got.grad_x, want.grad_y, got.grad_y,
                                     want.magnitude, got.magnitude);
                            $display("  row %0d/%0d col %0d/%0d last %b/%b pad %h",
                                     want.centre_row, got.centre_row,
                                     want.centre_col, got.centre_col,
                                     want.frame_last, m_tlast, got.pad);
                        end
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready   <= 1'b0;
                stall_left <= pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Block is idle once everything is sent and every result is back
    task automatic wait_idle();
        do @(posedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || gradient_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random pixels; optional frame restarts scattered in (width stays fixed)
    task automatic queue_pixels(input int unsigned n, input bit first_fs, input bit noisy);
        pixel_item_t item;
        int unsigned i;
        for (i = 0; i < n; i++) begin
            item.pixel = pick_pixel();
            item.frame_start = (i == 0) ? first_fs : (noisy && $urandom_range(0, 49) == 0);
            pixel_q.push_back(item);
        end
    endtask

    initial begin
        pixel_item_t item;
        int unsigned row_i, col_i, k, w_val, h_val, eff_w, eff_h, n;
        int unsigned frame_min_w, rand_items;
        bit fresh;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        frame_min_w = DEF_MAX_WIDTH;

        // Directed 4x7 frame: vertical extremes both ways, then a bar
        // pattern that gives horizontal extremes of both signs
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 7);
        for (row_i = 0; row_i < 7; row_i++) begin
            for (col_i = 0; col_i < 4; col_i++) begin
                if (row_i == 0 || row_i == 3) item.pixel = '1;
                else if (row_i >= 4 && (col_i == 1 || col_i == 2)) item.pixel = '1;
                else item.pixel = '0;
                item.frame_start = (row_i == 0 && col_i == 0);
                pixel_q.push_back(item);
            end
        end
        frame_min_w = 4;
        wait_idle();

        // 16x6 frame with no idling, so the receiver hold-off backs the
        // block up into its input
        no_idle = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 16);
        write_reg(REG_IMAGE_HEIGHT, 6);
        queue_pixels(16 * 6, 1'b1, 1'b0);
        frame_min_w = 16;
        wait_idle();
        no_idle = 1'b0;

        // Both dimensions clamped up from below range; two frames back to
        // back, the second one wrapping without a frame restart
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 2);
        queue_pixels(2 * MIN_DIM * MIN_DIM, 1'b1, 1'b0);
        frame_min_w = MIN_DIM;
        wait_idle();

        // Random phases: small frames mostly, some continuing mid-frame
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            k = $urandom_range(0, 99);
            if (k < 70) w_val = $urandom_range(3, 10);
            else if (k < 82) w_val = $urandom_range(0, 2);
            else if (k < 94) w_val = $urandom_range(11, 40);
            else w_val = $urandom_range(41, 511);
            k = $urandom_range(0, 99);
            if (k < 70) h_val = $urandom_range(3, 8);
            else if (k < 82) h_val = $urandom_range(0, 2);
            else if (k < 92) h_val = $urandom_range(9, 40);
            else h_val = $urandom_range(41, 511);
            write_reg(REG_IMAGE_WIDTH, w_val);
            write_reg(REG_IMAGE_HEIGHT, h_val);
            eff_w = clamp_dim(w_val, DEF_MAX_WIDTH);
            eff_h = clamp_dim(h_val, MAX_HEIGHT);

            // Continuing without a restart is only safe when rows get no wider
            fresh = (eff_w > frame_min_w) || ($urandom_range(0, 2) != 0);
            frame_min_w = eff_w;
            no_idle = ($urandom_range(0, 3) == 0);
            n = 2 * eff_w * eff_h;
            if (n > 150) n = 150;
            n = $urandom_range(1, n);
            queue_pixels(n, fresh, 1'b1);
            rand_items += n;
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (END_CYCLES) @(posedge aclk);
        if (gradient_q.size() != 0) begin
            $display("%0d results never arrived", gradient_q.size());
            mismatches += gradient_q.size();
        end
        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sgm_pkg.sv
rtl/sgm_ram.sv
rtl/sgm_isqrt.sv
rtl/sobel_gradient_magnitude_unit.sv
tb/sv/sobel_gradient_magnitude_unit_tb.sv
